FILE: hdl/light_uv_poly_fixed_eval_core_defines.svh
// Assertion macros for the light/UV polynomial evaluator
`ifndef LIGHT_UV_POLY_FIXED_EVAL_CORE_DEFINES_SVH
`define LIGHT_UV_POLY_FIXED_EVAL_CORE_DEFINES_SVH
`ifndef SYNTH
`define LUV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LUV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LUV_ASSERT(label, prop, msg)
`define LUV_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: hdl/luv_pkg.sv
`default_nettype none
package luv_pkg;

  // ROM word: info[31:16] (shift byte, sign/xo/yo byte), magnitude[15:0]
  localparam int RomDepth = 15;
  localparam logic [31:0] CoefRom [RomDepth] = '{
    // high-range lux table
    32'h0000_00D1, 32'h0681_005D, 32'h0810_0041, 32'hF591_00EA,
    // low-range lux table
    32'h0000_0000, 32'h0781_717D, 32'hFC02_8E0B, 32'h0910_5135,
    32'hFE91_E235, 32'hF912_9560, 32'hFDA0_B6B7, 32'hFA21_CA77,
    32'hF8A2_E630,
    // UV table
    32'h0501_78B6, 32'hFD82_B4DD
  };

  localparam logic [3:0] HighFirst = 4'd0;
  localparam logic [3:0] HighLast  = 4'd3;
  localparam logic [3:0] LowFirst  = 4'd4;
  localparam logic [3:0] LowLast   = 4'd12;
  localparam logic [3:0] UvFirst   = 4'd13;
  localparam logic [3:0] UvLast    = 4'd14;

  localparam logic [22:0] ThreshReset = 23'd16000;
  localparam int OutFrac = 12;

  typedef enum logic [2:0] {
    S_IDLE, S_TERM, S_SETUP, S_DIV, S_SHIFT, S_MUL, S_ACC, S_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/luv_ifs.sv
`default_nettype none
// sample channel: four signed sensor counts
interface luv_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] uv_count;
  logic signed [23:0] visible_high_count;
  logic signed [23:0] infrared_count;
  logic signed [23:0] visible_low_count;
  modport source (output valid, uv_count, visible_high_count, infrared_count,
                  visible_low_count, input ready);
  modport sink (input valid, uv_count, visible_high_count, infrared_count,
                visible_low_count, output ready);
endinterface

// result channel
interface luv_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] lux_value;
  logic [30:0] uv_index_value;
  logic        high_range_used;
  modport source (output valid, lux_value, uv_index_value, high_range_used,
                  input ready);
  modport sink (input valid, lux_value, uv_index_value, high_range_used,
                output ready);
endinterface

// threshold write channel
interface luv_cfg_if;
  logic        valid;
  logic        ready;
  logic [22:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/light_uv_poly_fixed_eval_core.sv
// Light/UV calibration polynomial evaluator.
// samples: one beat carries four signed 24-bit counts (uv, visible high,
//   infrared, visible low). results: one beat carries lux and UV index
//   (unsigned, 12 fraction bits, 31 bits) and the high-range flag.
// cfg: writes the 23-bit range threshold; always ready, write only while idle.
// Each non-constant term of the coefficient ROM runs on one shared restoring
// divider, one barrel shifter and one 32x32 multiplier.
// A term steps through term setup, then per factor setup, divide, shift and
// multiply (twice for a squared factor), then accumulate; a constant term
// goes from term setup straight to accumulate. The lux terms of the selected
// range run first, then the UV terms. A new sample is taken only while idle,
// so the next sample waits until the result has gone to the output register.
// A finished result sits in the output register until taken; the sequencer
// may run the next item meanwhile and waits at its end only if the register
// is still full. Reset (rst, synchronous) empties the pipeline and sets
// the threshold to 16000.
`default_nettype none
`include "light_uv_poly_fixed_eval_core_defines.svh"
module light_uv_poly_fixed_eval_core (
  input  wire logic clk,
  input  wire logic rst,
  luv_in_if.sink    samples,
  luv_out_if.source results,
  luv_cfg_if.sink   cfg
);
  import luv_pkg::*;

  state_t state, state_next;

  logic [22:0] thresh;
  logic [31:0] xv, yv, uvv;
  logic        high, phase, pass, mulsq, qneg;
  logic        frac_hi;
  logic [3:0]  idx;
  logic [31:0] dvd, fac, term, acc;
  logic [15:0] rem;
  logic [4:0]  cnt;
  logic [30:0] lux_res;
  logic        out_valid;
  logic [30:0] out_lux, out_uv;
  logic        out_high;

  // saturated magnitude of a finished sum
  function automatic logic [31:0] acc_abs_fin(input logic [31:0] a);
    if (a == 32'h8000_0000) return 32'h7FFF_FFFF;
    return a[31] ? (32'd0 - a) : a;
  endfunction

  // ROM entry decode
  logic [31:0] word;
  logic [15:0] mag;
  logic signed [7:0] sh;
  logic [2:0]  xo, yo, ord;
  logic        neg, is_const;
  assign word     = CoefRom[idx];
  assign mag      = word[15:0];
  assign sh       = word[31:24];
  assign neg      = word[23];
  assign xo       = word[22:20];
  assign yo       = word[18:16];
  assign is_const = (xo == 3'd0) && (yo == 3'd0);
  assign ord      = pass ? yo : xo;

  // range select
  logic high_sel;
  assign high_sel = (samples.visible_high_count > $signed({2'b00, thresh})) ||
                    (samples.infrared_count > $signed({2'b00, thresh}));

  // divider step and setup values
  logic [31:0] dshift, dabs;
  logic [16:0] rsh;
  logic        rge;
  assign dshift = (pass ? yv : xv) << (frac_hi ? 5'd15 : 5'd7);
  assign dabs   = dshift[31] ? (32'd0 - dshift) : dshift;
  assign rsh    = {rem, dvd[31]};
  assign rge    = rsh >= {1'b0, mag};

  // shifter
  logic [31:0] q, shf;
  logic [8:0]  rsa;
  assign q   = qneg ? (32'd0 - dvd) : dvd;
  assign rsa = 9'd0 - {sh[7], sh};
  assign shf = sh[7] ? 32'($signed(q) >>> rsa) : (q << sh[6:0]);

  // accumulate and absolute value
  logic [31:0] acc_new, acc_abs;
  assign acc_new = neg ? (acc - term) : (acc + term);
  assign acc_abs = (acc_new == 32'h8000_0000) ? 32'h7FFF_FFFF :
                   (acc_new[31] ? (32'd0 - acc_new) : acc_new);

  logic last;
  assign last = phase ? (idx == UvLast) : (high ? (idx == HighLast) : (idx == LowLast));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (samples.valid) state_next = S_TERM;
      S_TERM:  state_next = is_const ? S_ACC : S_SETUP;
      S_SETUP: begin
        if (ord != 3'd0) state_next = S_DIV;
        else if (pass) state_next = S_ACC;
      end
      S_DIV:   if (cnt == 5'd31) state_next = S_SHIFT;
      S_SHIFT: state_next = S_MUL;
      S_MUL: begin
        if (!mulsq) state_next = pass ? S_ACC : S_SETUP;
      end
      S_ACC:   state_next = (last && phase) ? S_FIN : S_TERM;
      S_FIN:   if (!out_valid || results.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    samples.ready           = (state == S_IDLE);
    cfg.ready               = 1'b1;
    results.valid           = out_valid;
    results.lux_value       = out_lux;
    results.uv_index_value  = out_uv;
    results.high_range_used = out_high;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      thresh    <= ThreshReset;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) thresh <= cfg.data;
      if (state == S_FIN && (!out_valid || results.ready)) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        uvv     <= 32'(samples.uv_count);
        xv      <= high_sel ? 32'(samples.visible_high_count)
                            : 32'(samples.visible_low_count);
        yv      <= 32'(samples.infrared_count);
        high    <= high_sel;
        frac_hi <= !high_sel;
        phase   <= 1'b0;
        idx     <= high_sel ? HighFirst : LowFirst;
        acc     <= 32'd0;
      end
      S_TERM: begin
        pass <= 1'b0;
        term <= is_const ? ({16'd0, mag} << OutFrac) : 32'd1;
      end
      S_SETUP: begin
        if (ord == 3'd0) pass <= 1'b1;
        else begin
          qneg  <= dshift[31];
          dvd   <= dabs;
          rem   <= 16'd0;
          cnt   <= 5'd0;
          mulsq <= ord > 3'd1;
        end
      end
      S_DIV: begin
        rem <= rge ? 16'(rsh - {1'b0, mag}) : rsh[15:0];
        dvd <= {dvd[30:0], rge};
        cnt <= cnt + 5'd1;
      end
      S_SHIFT: fac <= shf;
      S_MUL: begin
        term  <= 32'(term * fac);
        mulsq <= 1'b0;
        if (!mulsq) pass <= 1'b1;
      end
      S_ACC: begin
        if (last && !phase) begin
          lux_res <= acc_abs[30:0];
          phase   <= 1'b1;
          idx     <= UvFirst;
          acc     <= 32'd0;
          xv      <= 32'd0;
          yv      <= uvv;
          frac_hi <= 1'b1;
        end else begin
          acc <= acc_new;
          // hold the index on the last UV term
          if (!last) idx <= idx + 4'd1;
        end
      end
      S_FIN: begin
        if (!out_valid || results.ready) begin
          out_lux  <= lux_res;
          out_uv   <= 31'(acc_abs_fin(acc));
          out_high <= high;
        end
      end
      default: ;
    endcase
  end

  `LUV_ASSERT(a_start, samples.valid && samples.ready |=> state == S_TERM, "no start")
  `LUV_ASSERT(a_div, state == S_DIV && cnt != 5'd31 |=> state == S_DIV, "div cut short")
  `LUV_ASSERT(a_idx, state != S_IDLE |-> idx <= UvLast, "ROM index out of range")
  `LUV_ASSERT_RST(a_rst, rst |=> !results.valid && state == S_IDLE, "reset failed")

endmodule
`default_nettype wire
